@@ hw/rtl/ipv6_text_address_recognizer_defines.svh @@
// Assertion macros used by the checker of the IPv6 text address recognizer.
`ifndef IPV6_TEXT_ADDRESS_RECOGNIZER_DEFINES_SVH
`define IPV6_TEXT_ADDRESS_RECOGNIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPV6R_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ipv6r: same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define IPV6R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ipv6r: next-cycle implication violated");

`endif

@@ hw/rtl/ipv6r_pkg.sv @@
// Types and constants of the IPv6 text address recognizer.
`timescale 1ns / 1ps
`default_nettype none

package ipv6r_pkg;

    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] CH_DIG_LO  = 8'h30;
    localparam logic [7:0] CH_DIG_HI  = 8'h39;
    localparam logic [7:0] CH_LOW_LO  = 8'h61;
    localparam logic [7:0] CH_LOW_HI  = 8'h66;
    localparam logic [7:0] CH_UP_LO   = 8'h41;
    localparam logic [7:0] CH_UP_HI   = 8'h46;
    // offsets that map 'a' and 'A' to the value ten
    localparam logic [7:0] LOW_OFFSET = 8'h57;
    localparam logic [7:0] UP_OFFSET  = 8'h37;

    localparam logic [9:0] DEC_CAP        = 10'd1023;
    localparam logic [3:0] GROUPS_MAX     = 4'd7;
    localparam logic [3:0] PIECES_FULL    = 4'd8;
    localparam logic [3:0] PIECES_V4      = 4'd2;
    localparam logic [2:0] HEX_DIGITS_MAX = 3'd4;
    localparam logic [2:0] OCTETS_MAX     = 3'd3;
    localparam logic [3:0] DEC_DIGIT_MAX  = 4'd9;

    typedef enum logic [1:0] {
        CLS_COLON,
        CLS_DOT,
        CLS_HEX,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  hex_val;
        logic        last;
    } char_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/ipv6r_if.sv @@
// Valid/ready channel interfaces for characters in and verdicts out.
`timescale 1ns / 1ps
`default_nettype none

interface ipv6r_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ipv6r_result_if;
    logic       valid;
    logic       ready;
    logic       match;
    logic       compressed;
    logic       ipv4_tail;
    logic [3:0] piece_count;

    modport source (output valid, output match, output compressed, output ipv4_tail,
                    output piece_count, input ready);
    modport sink   (input valid, input match, input compressed, input ipv4_tail,
                    input piece_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ipv6_text_address_recognizer.sv @@
// Top level of the IPv6 text address recognizer.
//
//  channel  | dir | payload                                   | word
//  ---------+-----+-------------------------------------------+------------------------
//  chars    | in  | char_code[7:0], last_char                 | one character
//  result   | out | match, compressed, ipv4_tail, piece_count | one verdict per string
//
// One character word per cycle while chars.ready is high, the back end's update rate.
// A verdict is registered once its last character is popped from the queue.
// rst_n clears the queue, the running state and the output valid at once.
// A held verdict stalls the back end only at the next final character; the queue of
// QUEUE_DEPTH words then fills before chars.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module ipv6_text_address_recognizer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ipv6r_char_if.sink     chars,
    ipv6r_result_if.source result
);
    import ipv6r_pkg::*;

    logic       push;
    logic       q_full;
    logic       pop;
    logic       head_valid;
    char_item_t push_item;
    char_item_t head_item;

    ipv6r_front u_front (
        .chars  (chars),
        .q_full (q_full),
        .push   (push),
        .item   (push_item)
    );

    ipv6r_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    ipv6r_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

@@ hw/rtl/ipv6r_front.sv @@
// Front end: take character words and classify them for the queue.
`timescale 1ns / 1ps
`default_nettype none

module ipv6r_front (
    ipv6r_char_if.sink          chars,
    input  wire logic           q_full,
    output logic                push,
    output ipv6r_pkg::char_item_t item
);
    import ipv6r_pkg::*;

    logic [7:0] diff;

    assign chars.ready = !q_full;
    assign push        = chars.valid && !q_full;

    always_comb
    begin
        item.last    = chars.last_char;
        item.cls     = CLS_OTHER;
        item.hex_val = 4'd0;
        diff         = 8'd0;
        case (chars.char_code) inside
            COLON_CHAR:
            begin
                item.cls = CLS_COLON;
            end
            DOT_CHAR:
            begin
                item.cls = CLS_DOT;
            end
            [CH_DIG_LO:CH_DIG_HI]:
            begin
                item.cls     = CLS_HEX;
                diff         = chars.char_code - CH_DIG_LO;
                item.hex_val = diff[3:0];
            end
            [CH_LOW_LO:CH_LOW_HI]:
            begin
                item.cls     = CLS_HEX;
                diff         = chars.char_code - LOW_OFFSET;
                item.hex_val = diff[3:0];
            end
            [CH_UP_LO:CH_UP_HI]:
            begin
                item.cls     = CLS_HEX;
                diff         = chars.char_code - UP_OFFSET;
                item.hex_val = diff[3:0];
            end
            default:
            begin
                item.cls = CLS_OTHER;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/ipv6r_fifo.sv @@
// Short queue of classified characters between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module ipv6r_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire ipv6r_pkg::char_item_t push_item,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       head_valid,
    output ipv6r_pkg::char_item_t      head_item
);
    import ipv6r_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    char_item_t    mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ipv6r_back.sv @@
// Back end: running grammar state and the registered verdict word.
`timescale 1ns / 1ps
`default_nettype none

module ipv6r_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  head_valid,
    input  wire ipv6r_pkg::char_item_t head_item,
    output logic                       pop,
    ipv6r_result_if.source             result
);
    import ipv6r_pkg::*;

    // decimal octet: 1..3 digits, at most 255, no leading zero
    function automatic logic octet_ok(input logic all_dec, input logic [2:0] n,
                                      input logic [9:0] v);
        logic ok;
        ok = all_dec && (n >= 3'd1) && (n <= 3'd3) && (v <= 10'd255);
        if ((n == 3'd2) && (v < 10'd10))
        begin
            ok = 1'b0;
        end
        if ((n == 3'd3) && (v < 10'd100))
        begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    logic [3:0] groups_reg, groups_next, groups_upd;
    logic [2:0] hex_reg, hex_next, hex_upd;
    logic       zrun_reg, zrun_next, zrun_upd;
    logic       prev_colon_reg, prev_colon_next, prev_colon_upd;
    logic       all_dec_reg, all_dec_next, all_dec_upd;
    logic [9:0] dec_reg, dec_next, dec_upd;
    logic       ipv4_reg, ipv4_next, ipv4_upd;
    logic [2:0] oct_reg, oct_next, oct_upd;
    logic       failed_reg, failed_next, failed_upd;
    logic       at_start_reg, at_start_next;

    logic       out_valid_reg, out_valid_next;
    logic       match_reg, compressed_reg, ipv4_tail_reg;
    logic [3:0] piece_reg;

    logic        lone_lead;
    logic        is_letter;
    logic [13:0] dec_wide;
    logic [9:0]  dec_sat;
    logic [3:0]  pieces;
    logic        verdict;
    logic        finish;

    assign pop    = head_valid && (!head_item.last || !out_valid_reg || result.ready);
    assign finish = pop && head_item.last;

    assign lone_lead = prev_colon_reg && (groups_reg == 4'd0) && !zrun_reg;
    assign is_letter = head_item.hex_val > DEC_DIGIT_MAX;
    assign dec_wide  = {1'b0, dec_reg, 3'b000} + {3'b000, dec_reg, 1'b0}
                     + {10'd0, head_item.hex_val};
    assign dec_sat   = (dec_wide > {4'd0, DEC_CAP}) ? DEC_CAP : dec_wide[9:0];

    // apply one character to the running state
    always_comb
    begin
        groups_upd     = groups_reg;
        hex_upd        = hex_reg;
        zrun_upd       = zrun_reg;
        prev_colon_upd = prev_colon_reg;
        all_dec_upd    = all_dec_reg;
        dec_upd        = dec_reg;
        ipv4_upd       = ipv4_reg;
        oct_upd        = oct_reg;
        failed_upd     = failed_reg;
        if (!failed_reg)
        begin
            case (head_item.cls)
                CLS_COLON:
                begin
                    if (ipv4_reg)
                    begin
                        failed_upd = 1'b1;
                    end
                    else if (prev_colon_reg)
                    begin
                        if (zrun_reg)
                        begin
                            failed_upd = 1'b1;
                        end
                        else
                        begin
                            zrun_upd       = 1'b1;
                            prev_colon_upd = 1'b0;
                        end
                    end
                    else if (at_start_reg)
                    begin
                        prev_colon_upd = 1'b1;
                    end
                    else if ((hex_reg == 3'd0) || (groups_reg >= GROUPS_MAX))
                    begin
                        failed_upd = 1'b1;
                    end
                    else
                    begin
                        groups_upd     = groups_reg + 4'd1;
                        hex_upd        = 3'd0;
                        all_dec_upd    = 1'b1;
                        dec_upd        = 10'd0;
                        prev_colon_upd = 1'b1;
                    end
                end
                CLS_DOT:
                begin
                    if (lone_lead || !octet_ok(all_dec_reg, hex_reg, dec_reg))
                    begin
                        failed_upd = 1'b1;
                    end
                    else if (ipv4_reg && (oct_reg >= OCTETS_MAX))
                    begin
                        failed_upd = 1'b1;
                    end
                    else
                    begin
                        ipv4_upd       = 1'b1;
                        oct_upd        = ipv4_reg ? oct_reg + 3'd1 : 3'd1;
                        hex_upd        = 3'd0;
                        all_dec_upd    = 1'b1;
                        dec_upd        = 10'd0;
                        prev_colon_upd = 1'b0;
                    end
                end
                CLS_HEX:
                begin
                    if (lone_lead || (is_letter && ipv4_reg) || (hex_reg >= HEX_DIGITS_MAX))
                    begin
                        failed_upd = 1'b1;
                    end
                    else
                    begin
                        if (is_letter)
                        begin
                            all_dec_upd = 1'b0;
                        end
                        else
                        begin
                            dec_upd = dec_sat;
                        end
                        hex_upd        = hex_reg + 3'd1;
                        prev_colon_upd = 1'b0;
                    end
                end
                default:
                begin
                    failed_upd = 1'b1;
                end
            endcase
        end
    end

    // verdict on the state after the final character
    always_comb
    begin
        if (ipv4_upd)
        begin
            pieces = groups_upd + PIECES_V4;
        end
        else
        begin
            pieces = groups_upd + {3'd0, (hex_upd != 3'd0)};
        end
        verdict = !failed_upd && !prev_colon_upd
                && (!ipv4_upd || (octet_ok(all_dec_upd, hex_upd, dec_upd)
                                  && (oct_upd == OCTETS_MAX)))
                && (zrun_upd ? (pieces <= GROUPS_MAX) : (pieces == PIECES_FULL));
    end

    always_comb
    begin
        groups_next     = groups_reg;
        hex_next        = hex_reg;
        zrun_next       = zrun_reg;
        prev_colon_next = prev_colon_reg;
        all_dec_next    = all_dec_reg;
        dec_next        = dec_reg;
        ipv4_next       = ipv4_reg;
        oct_next        = oct_reg;
        failed_next     = failed_reg;
        at_start_next   = at_start_reg;
        if (finish)
        begin
            // clear for the next string
            groups_next     = 4'd0;
            hex_next        = 3'd0;
            zrun_next       = 1'b0;
            prev_colon_next = 1'b0;
            all_dec_next    = 1'b1;
            dec_next        = 10'd0;
            ipv4_next       = 1'b0;
            oct_next        = 3'd0;
            failed_next     = 1'b0;
            at_start_next   = 1'b1;
        end
        else if (pop)
        begin
            groups_next     = groups_upd;
            hex_next        = hex_upd;
            zrun_next       = zrun_upd;
            prev_colon_next = prev_colon_upd;
            all_dec_next    = all_dec_upd;
            dec_next        = dec_upd;
            ipv4_next       = ipv4_upd;
            oct_next        = oct_upd;
            failed_next     = failed_upd;
            at_start_next   = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg     <= 4'd0;
            hex_reg        <= 3'd0;
            zrun_reg       <= 1'b0;
            prev_colon_reg <= 1'b0;
            all_dec_reg    <= 1'b1;
            dec_reg        <= 10'd0;
            ipv4_reg       <= 1'b0;
            oct_reg        <= 3'd0;
            failed_reg     <= 1'b0;
            at_start_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            groups_reg     <= groups_next;
            hex_reg        <= hex_next;
            zrun_reg       <= zrun_next;
            prev_colon_reg <= prev_colon_next;
            all_dec_reg    <= all_dec_next;
            dec_reg        <= dec_next;
            ipv4_reg       <= ipv4_next;
            oct_reg        <= oct_next;
            failed_reg     <= failed_next;
            at_start_reg   <= at_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            match_reg      <= verdict;
            compressed_reg <= verdict && zrun_upd;
            ipv4_tail_reg  <= verdict && ipv4_upd;
            piece_reg      <= verdict ? pieces : 4'd0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match       = match_reg;
    assign result.compressed  = compressed_reg;
    assign result.ipv4_tail   = ipv4_tail_reg;
    assign result.piece_count = piece_reg;

endmodule

`default_nettype wire

@@ hw/rtl/ipv6r_chk.sv @@
// Port-level checker for the IPv6 text address recognizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "ipv6_text_address_recognizer_defines.svh"

module ipv6r_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       res_match,
    input wire logic       res_compressed,
    input wire logic       res_ipv4_tail,
    input wire logic [3:0] res_piece_count
);
    import ipv6r_pkg::*;

    // hold a stalled verdict word
    `IPV6R_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable({res_match, res_compressed, res_ipv4_tail, res_piece_count}))

    // a rejected string reports nothing else
    `IPV6R_ASSERT_IMPLY(a_reject_clean, clk, rst_n, res_valid && !res_match, !res_compressed && !res_ipv4_tail && (res_piece_count == 4'd0))

    // a full address without a zero run has exactly eight pieces, with one at most seven
    `IPV6R_ASSERT_IMPLY(a_piece_span, clk, rst_n, res_valid && res_match, res_compressed ? (res_piece_count <= GROUPS_MAX) : (res_piece_count == PIECES_FULL))

    // a dotted tail contributes two pieces, so the count is at least two
    `IPV6R_ASSERT_IMPLY(a_v4_pieces, clk, rst_n, res_valid && res_match && res_ipv4_tail, res_piece_count >= PIECES_V4)

endmodule

bind ipv6_text_address_recognizer ipv6r_chk u_ipv6r_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_match       (result.match),
    .res_compressed  (result.compressed),
    .res_ipv4_tail   (result.ipv4_tail),
    .res_piece_count (result.piece_count)
);

`default_nettype wire
